/* design/gdd_pkg.sv */
// ----------------------------------------------------------------------------
// gdd_pkg
// Shared types, widths, codes and calendar helpers for the Gregorian
// date decrement core.
// ----------------------------------------------------------------------------
package gdd_pkg;

	localparam int DayW  = 5;
	localparam int MonW  = 4;
	localparam int YearW = 16;
	localparam int AmtW  = 15;
	localparam int OpW   = 2;
	localparam int CntW  = AmtW + 3;   // weeks amount times seven
	localparam int R25W  = 5;          // year mod 25, 0..24
	localparam int BiasW = YearW;      // year with sign bit flipped
	localparam int RecW  = 13;
	localparam int ProdW = BiasW + RecW;
	localparam int RecShift = 17;      // floor(u / 25) ~= (u * 5243) >> 17
	localparam int QuoW  = ProdW - RecShift;
	localparam int RemW  = BiasW + 1;

	localparam logic [RecW-1:0]        Recip25  = 13'd5243;
	localparam logic [R25W-1:0]        Mod25Top = 5'd24;
	localparam logic [R25W-1:0]        Mod25Val = 5'd25;
	// (u - 32768) mod 25 == (u mod 25 + 7) mod 25
	localparam logic [R25W-1:0]        BiasAdj  = 5'd7;
	// 32767 mod 25, the residue after wrapping below the minimum year
	localparam logic [R25W-1:0]        R25AtMax = 5'd17;
	localparam logic signed [YearW-1:0] YearMin = 16'sh8000;

	localparam logic [MonW-1:0] MonJan = 4'd1;
	localparam logic [MonW-1:0] MonFeb = 4'd2;
	localparam logic [MonW-1:0] MonDec = 4'd12;
	localparam logic [DayW-1:0] DayFirst = 5'd1;

	typedef enum logic [OpW-1:0] {
		OP_DAYS   = 2'd0,
		OP_WEEKS  = 2'd1,
		OP_MONTHS = 2'd2,
		OP_YEARS  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_FIX,
		ST_RUN
	} state_t;

	typedef struct packed {
		logic [DayW-1:0]         day;
		logic [MonW-1:0]         month;
		logic signed [YearW-1:0] year;
		logic [R25W-1:0]         r25;
	} date_t;

	typedef struct packed {
		logic idle;
		logic mul;
		logic fix;
		logic step;
		logic finish;
	} ctrl_t;

	typedef struct packed {
		logic in_valid;
		logic is_years;
		logic cnt_zero;
		logic out_free;
	} stat_t;

	function automatic logic [DayW-1:0] month_len(input logic [MonW-1:0] m, input logic lp);
		logic [DayW-1:0] len;
		begin
			unique case (m)
				4'd2:                   len = lp ? 5'd29 : 5'd28;
				4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
				default:                len = 5'd31;
			endcase
			return len;
		end
	endfunction

endpackage

/* design/gdd_if.sv */
// ----------------------------------------------------------------------------
// gdd_if
// Valid/ready channels for requests and results of the date decrement core.
// ----------------------------------------------------------------------------
interface gdd_req_if;
	logic                             valid;
	logic                             ready;
	logic [gdd_pkg::OpW-1:0]          op;
	logic [gdd_pkg::AmtW-1:0]         amount;
	logic [gdd_pkg::DayW-1:0]         start_day;
	logic [gdd_pkg::MonW-1:0]         start_month;
	logic signed [gdd_pkg::YearW-1:0] start_year;

	modport source (output valid, op, amount, start_day, start_month, start_year,
		input ready);
	modport sink (input valid, op, amount, start_day, start_month, start_year,
		output ready);
endinterface

interface gdd_rsp_if;
	logic                             valid;
	logic                             ready;
	logic [gdd_pkg::DayW-1:0]         day;
	logic [gdd_pkg::MonW-1:0]         month;
	logic signed [gdd_pkg::YearW-1:0] year;

	modport source (output valid, day, month, year, input ready);
	modport sink (input valid, day, month, year, output ready);
endinterface

/* design/gregorian_date_decrement_core.sv */
// ----------------------------------------------------------------------------
// gregorian_date_decrement_core
// Moves a Gregorian date back by days, weeks, months or years.
// ----------------------------------------------------------------------------
// Usage:
//   req (sink): op, amount, start_day, start_month, start_year. An item is
//     taken when valid and ready are high at a clock edge. ready is high only
//     while the core is idle; one item is in work at a time.
//   rsp (source): day, month, year, held in an output register until taken.
//     The core goes back to idle and takes the next item while a result
//     still waits in that register.
// Work per item (from accept to rsp valid):
//   years      : plain 16-bit subtract, no stepping
//   days/months: amount steps (one day or one month per cycle)
//   weeks      : 7*amount day steps
//   The single step unit (one day or one month a cycle) sets this; for other
//   ops the MUL and FIX states compute year mod 25 by a reciprocal multiply first.
// Stall: if the previous result is still not taken when the loop ends, the
//   core holds in its last state until the output register frees up.
// Reset: arst_n clears the sequencer and the output valid; no result is
//   pending afterwards.
// ----------------------------------------------------------------------------
module gregorian_date_decrement_core (
	input logic      clk,
	input logic      arst_n,
	gdd_req_if.sink  req,
	gdd_rsp_if.source rsp
);

	gdd_pkg::ctrl_t ctrl;
	gdd_pkg::stat_t stat;

	gdd_pkg::date_t               date_q;
	gdd_pkg::date_t               date_step;
	gdd_pkg::date_t               date_load;
	logic [gdd_pkg::CntW-1:0]     cnt_q;
	logic [gdd_pkg::CntW-1:0]     cnt_load;
	logic                         month_mode_q;
	logic [gdd_pkg::ProdW-1:0]    prod_q;
	logic [gdd_pkg::BiasW-1:0]    ubias;
	logic [gdd_pkg::QuoW-1:0]     quo;
	logic [gdd_pkg::RemW-1:0]     quo25;
	logic [gdd_pkg::RemW-1:0]     diff;
	logic [gdd_pkg::R25W:0]       rem_u;
	logic [gdd_pkg::R25W:0]       rem_adj;
	logic [gdd_pkg::R25W-1:0]     r25_init;
	logic                         accept;
	logic                         out_valid_q;
	logic [gdd_pkg::DayW-1:0]     day_q;
	logic [gdd_pkg::MonW-1:0]     month_q;
	logic signed [gdd_pkg::YearW-1:0] year_q;
	gdd_pkg::op_t                 op_in;

	assign op_in  = gdd_pkg::op_t'(req.op);
	assign accept = req.valid && ctrl.idle;

	assign stat.in_valid = req.valid;
	assign stat.is_years = (op_in == gdd_pkg::OP_YEARS);
	assign stat.cnt_zero = (cnt_q == '0);
	assign stat.out_free = !out_valid_q || rsp.ready;

	gdd_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.stat  (stat),
		.ctrl  (ctrl)
	);

	gdd_step_unit u_step (
		.cur       (date_q),
		.month_mode(month_mode_q),
		.nxt       (date_step)
	);

	// normalize the start date; a years op finishes here
	always_comb begin
		date_load.day   = (req.start_day == '0) ? gdd_pkg::DayFirst : req.start_day;
		date_load.month = (req.start_month == '0) ? gdd_pkg::MonJan :
			(req.start_month > gdd_pkg::MonDec) ? gdd_pkg::MonDec : req.start_month;
		date_load.year  = req.start_year;
		date_load.r25   = '0;
		if (op_in == gdd_pkg::OP_YEARS) begin
			date_load.year = req.start_year - $signed({1'b0, req.amount});
		end
	end

	always_comb begin
		unique case (op_in)
			gdd_pkg::OP_WEEKS:
				cnt_load = {req.amount, 3'b000} - gdd_pkg::CntW'(req.amount);
			gdd_pkg::OP_YEARS:
				cnt_load = '0;
			default:
				cnt_load = gdd_pkg::CntW'(req.amount);
		endcase
	end

	// year mod 25 from the offset year u = year + 32768
	always_comb begin
		ubias    = {~date_q.year[gdd_pkg::YearW-1], date_q.year[gdd_pkg::YearW-2:0]};
		quo      = prod_q[gdd_pkg::ProdW-1:gdd_pkg::RecShift];
		quo25    = {quo, 4'b0000} + {1'b0, quo, 3'b000} + gdd_pkg::RemW'(quo);
		diff     = {1'b0, ubias} - quo25;
		// quotient estimate can be one high
		rem_u    = diff[gdd_pkg::RemW-1] ?
			{1'b0, gdd_pkg::R25W'(diff + gdd_pkg::RemW'(gdd_pkg::Mod25Val))} :
			{1'b0, gdd_pkg::R25W'(diff)};
		rem_adj  = rem_u + {1'b0, gdd_pkg::BiasAdj};
		r25_init = (rem_adj >= {1'b0, gdd_pkg::Mod25Val}) ?
			gdd_pkg::R25W'(rem_adj - {1'b0, gdd_pkg::Mod25Val}) :
			gdd_pkg::R25W'(rem_adj);
	end

	// working registers
	always_ff @(posedge clk) begin
		if (accept) begin
			date_q       <= date_load;
			cnt_q        <= cnt_load;
			month_mode_q <= (op_in == gdd_pkg::OP_MONTHS);
		end else if (ctrl.fix) begin
			date_q.r25 <= r25_init;
		end else if (ctrl.step) begin
			date_q <= date_step;
			cnt_q  <= cnt_q - gdd_pkg::CntW'(1);
		end
		if (ctrl.mul) begin
			prod_q <= gdd_pkg::ProdW'(ubias) * gdd_pkg::ProdW'(gdd_pkg::Recip25);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.finish) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.finish) begin
			day_q   <= date_q.day;
			month_q <= date_q.month;
			year_q  <= date_q.year;
		end
	end

	assign req.ready = ctrl.idle;
	assign rsp.valid = out_valid_q;
	assign rsp.day   = day_q;
	assign rsp.month = month_q;
	assign rsp.year  = year_q;

endmodule

/* design/gdd_step_unit.sv */
// ----------------------------------------------------------------------------
// gdd_step_unit
// Shared stepping unit: moves a date back by one day or one month.
// ----------------------------------------------------------------------------
module gdd_step_unit (
	input  gdd_pkg::date_t cur,
	input  logic           month_mode,
	output gdd_pkg::date_t nxt
);

	logic                        wrap;
	gdd_pkg::date_t              prev_m;
	logic                        lp;
	logic [gdd_pkg::DayW-1:0]    len;
	logic [gdd_pkg::R25W-1:0]    r25_dec;

	// residue of year - 1, with the wrap past the minimum year
	always_comb begin
		priority if (cur.year == gdd_pkg::YearMin) begin
			r25_dec = gdd_pkg::R25AtMax;
		end else if (cur.r25 == '0) begin
			r25_dec = gdd_pkg::Mod25Top;
		end else begin
			r25_dec = cur.r25 - gdd_pkg::R25W'(1);
		end
	end

	// date one month earlier, day untouched
	always_comb begin
		wrap   = (cur.month == gdd_pkg::MonJan);
		prev_m = cur;
		if (wrap) begin
			prev_m.month = gdd_pkg::MonDec;
			prev_m.year  = cur.year - 16'sd1;
			prev_m.r25   = r25_dec;
		end else begin
			prev_m.month = cur.month - gdd_pkg::MonW'(1);
		end
	end

	// leap: div by 4 and (not div by 25, or div by 16)
	always_comb begin
		lp  = (prev_m.year[1:0] == 2'b00) &&
			((prev_m.r25 != '0) || (prev_m.year[3:0] == 4'b0000));
		len = gdd_pkg::month_len(prev_m.month, lp);
	end

	always_comb begin
		nxt = cur;
		if (month_mode) begin
			nxt = prev_m;
			if (cur.day > len) begin
				nxt.day = len;
			end
		end else if (cur.day == gdd_pkg::DayFirst) begin
			nxt     = prev_m;
			nxt.day = len;
		end else begin
			nxt.day = cur.day - gdd_pkg::DayW'(1);
		end
	end

endmodule

/* design/gdd_ctrl.sv */
// ----------------------------------------------------------------------------
// gdd_ctrl
// Sequencer: load, residue setup (multiply, fix; skipped for years), step loop, hand-off.
// ----------------------------------------------------------------------------
module gdd_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  gdd_pkg::stat_t stat,
	output gdd_pkg::ctrl_t ctrl
);

	gdd_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gdd_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			gdd_pkg::ST_IDLE: begin
				if (stat.in_valid) begin
					state_d = stat.is_years ? gdd_pkg::ST_RUN : gdd_pkg::ST_MUL;
				end
			end
			gdd_pkg::ST_MUL: state_d = gdd_pkg::ST_FIX;
			gdd_pkg::ST_FIX: state_d = gdd_pkg::ST_RUN;
			gdd_pkg::ST_RUN: begin
				if (stat.cnt_zero && stat.out_free) begin
					state_d = gdd_pkg::ST_IDLE;
				end
			end
			default: state_d = gdd_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		ctrl.idle   = (state_q == gdd_pkg::ST_IDLE);
		ctrl.mul    = (state_q == gdd_pkg::ST_MUL);
		ctrl.fix    = (state_q == gdd_pkg::ST_FIX);
		ctrl.step   = (state_q == gdd_pkg::ST_RUN) && !stat.cnt_zero;
		ctrl.finish = (state_q == gdd_pkg::ST_RUN) && stat.cnt_zero && stat.out_free;
	end

endmodule

/* design/gdd_checker.sv */
// ----------------------------------------------------------------------------
// gdd_checker
// Port-level checks for the date decrement core, bound to the top level.
// ----------------------------------------------------------------------------
module gdd_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_ready,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic [gdd_pkg::DayW-1:0]   out_day,
	input logic [gdd_pkg::MonW-1:0]   out_month,
	input logic [gdd_pkg::YearW-1:0]  out_year
);

	// one item at a time: busy right after a take
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("core ready right after taking an item");

	// a new result shows up together with the return to idle
	a_idle_on_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> in_ready)
		else $error("result appeared while core still busy");

	// results are normalized dates
	a_date_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_day != '0) && (out_month != '0) &&
			(out_month <= gdd_pkg::MonDec))
		else $error("result date out of range");

	a_hold_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_day) &&
			$stable(out_month) && $stable(out_year))
		else $error("stalled result changed");

endmodule

bind gregorian_date_decrement_core gdd_checker u_gdd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (req.valid),
	.in_ready (req.ready),
	.out_valid(rsp.valid),
	.out_ready(rsp.ready),
	.out_day  (rsp.day),
	.out_month(rsp.month),
	.out_year (rsp.year)
);
